@@ sv/complex_arithmetic_unit_assert.svh @@
// assertion macros shared by the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define CAU_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked only out of reset
`define CAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/cau_pkg.sv @@
// types and constants of the complex arithmetic unit
`default_nettype none
package cau_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam int PROD_BITS = 2 * WORD_BITS;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [1:0]                  func;
    logic signed [WORD_BITS-1:0] a_real;
    logic signed [WORD_BITS-1:0] a_imag;
    logic signed [WORD_BITS-1:0] b_real;
    logic signed [WORD_BITS-1:0] b_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_real;
    logic signed [WORD_BITS-1:0] res_imag;
    logic [1:0]                  status;
  } cau_out_t;

  // classified item between front and back
  typedef struct packed {
    op_t                         op;
    logic                        dz;
    logic signed [WORD_BITS-1:0] ar;
    logic signed [WORD_BITS-1:0] ai;
    logic signed [WORD_BITS-1:0] br;
    logic signed [WORD_BITS-1:0] bi;
  } cau_entry_t;

endpackage
`default_nettype wire

@@ sv/cau_front.sv @@
// front end: decodes the operation and flags a zero divisor
`default_nettype none
module cau_front (
  input  cau_pkg::cau_in_t    in_data,
  output cau_pkg::cau_entry_t entry
);
  always_comb begin
    entry.op = cau_pkg::op_t'(in_data.func);
    entry.ar = in_data.a_real;
    entry.ai = in_data.a_imag;
    entry.br = in_data.b_real;
    entry.bi = in_data.b_imag;
    unique case (cau_pkg::op_t'(in_data.func))
      cau_pkg::OP_DIV: entry.dz = (in_data.b_real == '0) && (in_data.b_imag == '0);
      default:         entry.dz = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/cau_queue.sv @@
// two-entry queue between front and back
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"
module cau_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  cau_pkg::cau_entry_t  push_data,
  output logic                 full,
  input  wire                  pop,
  output logic                 not_empty,
  output cau_pkg::cau_entry_t  pop_data
);
  cau_pkg::cau_entry_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  `CAU_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full || pop)
  `CAU_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, not_empty)
endmodule
`default_nettype wire

@@ sv/cau_div.sv @@
// pipelined restoring divider: min(floor(mag * 2^frac / den), 2^word)
`default_nettype none
module cau_div (
  input  wire                                   clk,
  input  wire                                   en,
  input  wire [cau_pkg::PROD_BITS-1:0]          mag,
  input  wire [cau_pkg::PROD_BITS-1:0]          den,
  output logic [cau_pkg::WORD_BITS:0]           quo
);
  localparam int W  = cau_pkg::WORD_BITS;
  localparam int PW = cau_pkg::PROD_BITS;
  localparam int F  = cau_pkg::FRAC_BITS;
  localparam int NW = PW + F;
  localparam int CW = 3 * W;

  logic [PW:0]   rem_r [W+1];
  logic [W-1:0]  lo_r  [W+1];
  logic [W-1:0]  q_r   [W+1];
  logic          ovf_r [W+1];
  logic [PW-1:0] den_r [W+1];

  logic [NW-1:0] num;
  assign num = {mag, {F{1'b0}}};

  // first stage: quotient overflow test and the high part of the numerator
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= CW'(num) >= (CW'(den) << W);
      rem_r[0] <= (PW+1)'(num >> W);
      lo_r[0]  <= num[W-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
    end
  end

  // one quotient bit per stage
  for (genvar s = 0; s < W; s++) begin : g_step
    logic [PW:0] trial;
    logic        ge;
    assign trial = {rem_r[s][PW-1:0], lo_r[s][W-1]};
    assign ge    = trial >= {1'b0, den_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? trial - {1'b0, den_r[s]} : trial;
        lo_r[s+1]  <= {lo_r[s][W-2:0], 1'b0};
        q_r[s+1]   <= {q_r[s][W-2:0], ge};
        ovf_r[s+1] <= ovf_r[s];
        den_r[s+1] <= den_r[s];
      end
    end
  end

  assign quo = ovf_r[W] ? {1'b1, {W{1'b0}}} : {1'b0, q_r[W]};
endmodule
`default_nettype wire

@@ sv/cau_back.sv @@
// back end: product, sum, divide and saturation pipeline with output register
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"
module cau_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 item_valid,
  input  cau_pkg::cau_entry_t item,
  output logic                item_take,
  output logic                out_valid,
  input  wire                 out_ready,
  output cau_pkg::cau_out_t   out_data
);
  localparam int W  = cau_pkg::WORD_BITS;
  localparam int PW = cau_pkg::PROD_BITS;
  localparam int F  = cau_pkg::FRAC_BITS;

  logic adv;
  assign adv       = !out_valid || out_ready;
  assign item_take = adv && item_valid;

  // product stage
  logic                 p_v_r;
  cau_pkg::op_t         p_op_r;
  logic                 p_dz_r;
  logic signed [W-1:0]  p_ar_r, p_ai_r, p_br_r, p_bi_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_sr_r, p_si_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p_v_r <= 1'b0;
    else if (adv) p_v_r <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_op_r <= item.op;
      p_dz_r <= item.dz;
      p_ar_r <= item.ar;
      p_ai_r <= item.ai;
      p_br_r <= item.br;
      p_bi_r <= item.bi;
      p_rr_r <= item.ar * item.br;
      p_ii_r <= item.ai * item.bi;
      p_ir_r <= item.ai * item.br;
      p_ri_r <= item.ar * item.bi;
      p_sr_r <= item.br * item.br;
      p_si_r <= item.bi * item.bi;
    end
  end

  // sum stage: sign and magnitude of each part, divisor
  logic signed [PW:0] re_t1, re_t2, im_t1, im_t2, re_sum, im_sum;
  logic [PW-1:0]      re_abs, im_abs, re_mag, im_mag, den;

  always_comb begin
    re_t1 = (PW+1)'(p_rr_r);
    re_t2 = -(PW+1)'(p_ii_r);
    im_t1 = (PW+1)'(p_ir_r);
    im_t2 = (PW+1)'(p_ri_r);
    unique case (p_op_r)
      cau_pkg::OP_ADD: begin
        re_t1 = (PW+1)'(p_ar_r);
        re_t2 = (PW+1)'(p_br_r);
        im_t1 = (PW+1)'(p_ai_r);
        im_t2 = (PW+1)'(p_bi_r);
      end
      cau_pkg::OP_SUB: begin
        re_t1 = (PW+1)'(p_ar_r);
        re_t2 = -(PW+1)'(p_br_r);
        im_t1 = (PW+1)'(p_ai_r);
        im_t2 = -(PW+1)'(p_bi_r);
      end
      cau_pkg::OP_MUL: begin
      end
      cau_pkg::OP_DIV: begin
        re_t2 = (PW+1)'(p_ii_r);
        im_t2 = -(PW+1)'(p_ri_r);
      end
      default: begin
      end
    endcase
    re_sum = re_t1 + re_t2;
    im_sum = im_t1 + im_t2;
    re_abs = re_sum[PW] ? PW'(-re_sum) : re_sum[PW-1:0];
    im_abs = im_sum[PW] ? PW'(-im_sum) : im_sum[PW-1:0];
    re_mag = (p_op_r == cau_pkg::OP_MUL) ? (re_abs >> F) : re_abs;
    im_mag = (p_op_r == cau_pkg::OP_MUL) ? (im_abs >> F) : im_abs;
    den    = p_sr_r[PW-1:0] + p_si_r[PW-1:0];
  end

  logic                 s_v_r;
  cau_pkg::op_t         s_op_r;
  logic                 s_dz_r, s_rn_r, s_in_r;
  logic [PW-1:0]        s_rm_r, s_im_r, s_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r <= 1'b0;
    else if (adv) s_v_r <= p_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_op_r  <= p_op_r;
      s_dz_r  <= p_dz_r;
      s_rn_r  <= re_sum[PW];
      s_in_r  <= im_sum[PW];
      s_rm_r  <= re_mag;
      s_im_r  <= im_mag;
      s_den_r <= den;
    end
  end

  // dividers, one per part, with side data delayed alongside
  logic [W:0] re_quo, im_quo;

  cau_div u_div_re (.clk(clk), .en(adv), .mag(s_rm_r), .den(s_den_r), .quo(re_quo));
  cau_div u_div_im (.clk(clk), .en(adv), .mag(s_im_r), .den(s_den_r), .quo(im_quo));

  logic          d_v_r  [W+1];
  cau_pkg::op_t  d_op_r [W+1];
  logic          d_dz_r [W+1];
  logic          d_rn_r [W+1];
  logic          d_in_r [W+1];
  logic [PW-1:0] d_rm_r [W+1];
  logic [PW-1:0] d_im_r [W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= W; i++) d_v_r[i] <= 1'b0;
    end else if (adv) begin
      d_v_r[0] <= s_v_r;
      for (int i = 1; i <= W; i++) d_v_r[i] <= d_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_op_r[0] <= s_op_r;
      d_dz_r[0] <= s_dz_r;
      d_rn_r[0] <= s_rn_r;
      d_in_r[0] <= s_in_r;
      d_rm_r[0] <= s_rm_r;
      d_im_r[0] <= s_im_r;
      for (int i = 1; i <= W; i++) begin
        d_op_r[i] <= d_op_r[i-1];
        d_dz_r[i] <= d_dz_r[i-1];
        d_rn_r[i] <= d_rn_r[i-1];
        d_in_r[i] <= d_in_r[i-1];
        d_rm_r[i] <= d_rm_r[i-1];
        d_im_r[i] <= d_im_r[i-1];
      end
    end
  end

  // saturate sign and magnitude to a word
  localparam logic [PW-1:0] POS_LIM = PW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [PW-1:0] NEG_LIM = PW'(64'd1 << (W - 1));

  logic [PW-1:0]  fr_mag, fi_mag;
  logic           re_sat, im_sat;
  logic [W-1:0]   re_val, im_val;
  cau_pkg::cau_out_t res_nxt;

  always_comb begin
    fr_mag = (d_op_r[W] == cau_pkg::OP_DIV) ? PW'(re_quo) : d_rm_r[W];
    fi_mag = (d_op_r[W] == cau_pkg::OP_DIV) ? PW'(im_quo) : d_im_r[W];
    if (d_rn_r[W]) begin
      re_sat = fr_mag > NEG_LIM;
      re_val = re_sat ? NEG_LIM[W-1:0] : W'(-fr_mag);
    end else begin
      re_sat = fr_mag > POS_LIM;
      re_val = re_sat ? POS_LIM[W-1:0] : fr_mag[W-1:0];
    end
    if (d_in_r[W]) begin
      im_sat = fi_mag > NEG_LIM;
      im_val = im_sat ? NEG_LIM[W-1:0] : W'(-fi_mag);
    end else begin
      im_sat = fi_mag > POS_LIM;
      im_val = im_sat ? POS_LIM[W-1:0] : fi_mag[W-1:0];
    end
    if (d_dz_r[W]) begin
      res_nxt.res_real = '0;
      res_nxt.res_imag = '0;
      res_nxt.status   = cau_pkg::ST_DZ;
    end else begin
      res_nxt.res_real = re_val;
      res_nxt.res_imag = im_val;
      res_nxt.status   = (re_sat || im_sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= d_v_r[W];
  end

  always_ff @(posedge clk) begin
    if (adv) out_data <= res_nxt;
  end

  `CAU_ASSERT_IMPL(a_dz_zero, clk, rst_n, out_valid && (out_data.status == cau_pkg::ST_DZ),
    (out_data.res_real == '0) && (out_data.res_imag == '0))
  `CAU_ASSERT_IMPL(a_sat_limit, clk, rst_n, out_valid && (out_data.status == cau_pkg::ST_SAT),
    (out_data.res_real == POS_LIM[W-1:0]) || (out_data.res_real == NEG_LIM[W-1:0]) ||
    (out_data.res_imag == POS_LIM[W-1:0]) || (out_data.res_imag == NEG_LIM[W-1:0]))
  `CAU_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

@@ sv/complex_arithmetic_unit.sv @@
// top level of the complex arithmetic unit
// complex add, subtract, multiply and divide on signed q8.8 operands, one beat per
// cycle in and out while results are taken. a beat enters a two-entry queue after
// decode, then runs through a pipeline: products, sums, a restoring divider and
// saturation. the pipeline stalls as a whole only while the output register holds a
// result nobody takes; the queue takes up to two more beats meanwhile and then drops
// in_ready until the pipeline moves again. results are truncated toward zero and
// clamped to the word range with status 1; a zero divisor gives a zero result with
// status 2
`default_nettype none
module complex_arithmetic_unit (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  cau_pkg::cau_in_t  in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output cau_pkg::cau_out_t out_data
);
  cau_pkg::cau_entry_t fe_entry, q_entry;
  logic q_full, q_not_empty, q_pop;

  // decode and zero-divisor detect
  cau_front u_front (.in_data(in_data), .entry(fe_entry));

  assign in_ready = !q_full;

  // decouples intake from the arithmetic pipeline
  cau_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in_valid && in_ready), .push_data(fe_entry), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .pop_data(q_entry)
  );

  // arithmetic pipeline and output register
  cau_back u_back (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_not_empty), .item(q_entry), .item_take(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire

@@ verif/tb_complex_arithmetic_unit.sv @@
// self-checking testbench for the complex arithmetic unit
`default_nettype none
module tb_complex_arithmetic_unit;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // dut ports, inputs driven to known values from time zero
  logic              in_valid = 1'b0;
  logic              in_ready;
  cau_pkg::cau_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cau_pkg::cau_out_t out_data;

  complex_arithmetic_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // results still owed by the dut, oldest first
  cau_pkg::cau_out_t pending_results[$];
  int       error_count = 0;
  int       result_count = 0;
  int       op_count[4] = '{0, 0, 0, 0};
  int       sat_count = 0;
  int       dz_count = 0;

  // idling controls
  bit sender_idle_en = 1'b0;
  bit receiver_idle_en = 1'b0;
  int hold_request = 0;

  localparam longint POS_LIMIT = (64'sd1 <<< (cau_pkg::WORD_BITS - 1)) - 1;
  localparam longint NEG_LIMIT = -(64'sd1 <<< (cau_pkg::WORD_BITS - 1));
  localparam longint ONE_Q = 64'sd1 <<< cau_pkg::FRAC_BITS;

  // clamp one part to the word range, noting a clamp
  function automatic logic [cau_pkg::WORD_BITS-1:0] clamp_part(input longint v,
                                                               inout logic hit);
    if (v > POS_LIMIT) begin
      hit = 1'b1;
      v = POS_LIMIT;
    end else if (v < NEG_LIMIT) begin
      hit = 1'b1;
      v = NEG_LIMIT;
    end
    return v[cau_pkg::WORD_BITS-1:0];
  endfunction

  // expected complex result; signed division truncates toward zero as the block does
  function automatic cau_pkg::cau_out_t complex_result(input cau_pkg::cau_in_t x);
    cau_pkg::cau_out_t r;
    longint   ar, ai, br, bi, re, im, den;
    logic     hit;
    ar = longint'(x.a_real);
    ai = longint'(x.a_imag);
    br = longint'(x.b_real);
    bi = longint'(x.b_imag);
    hit = 1'b0;
    r = '0;
    case (cau_pkg::op_t'(x.func))
      cau_pkg::OP_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      cau_pkg::OP_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      cau_pkg::OP_MUL: begin
        re = (ar * br - ai * bi) / ONE_Q;
        im = (ai * br + ar * bi) / ONE_Q;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.status = cau_pkg::ST_DZ;
          return r;
        end
        re = ((ar * br + ai * bi) * ONE_Q) / den;
        im = ((ai * br - ar * bi) * ONE_Q) / den;
      end
    endcase
    r.res_real = clamp_part(re, hit);
    r.res_imag = clamp_part(im, hit);
    r.status = hit ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    return r;
  endfunction

  // send one beat, with an optional idle gap before it
  task automatic send_beat(input cau_pkg::cau_in_t x);
    int  gap;
    bit  took;
    gap = 0;
    if (sender_idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    // ready is stable by the falling edge, so sample it there
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    pending_results.push_back(complex_result(x));
    op_count[x.func]++;
  endtask

  task automatic finish_sending();
    in_valid <= 1'b0;
  endtask

  function automatic cau_pkg::cau_in_t make_beat(input logic [1:0] f, input int ar,
                                                 input int ai, input int br, input int bi);
    cau_pkg::cau_in_t x;
    x.func = f;
    x.a_real = ar[cau_pkg::WORD_BITS-1:0];
    x.a_imag = ai[cau_pkg::WORD_BITS-1:0];
    x.b_real = br[cau_pkg::WORD_BITS-1:0];
    x.b_imag = bi[cau_pkg::WORD_BITS-1:0];
    return x;
  endfunction

  // operand word: full range, small values, extremes or zero
  function automatic int rand_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom_range(0, 65535) - 32768;
      2: return $urandom_range(0, 2048) - 1024;
      3: return $urandom_range(0, 64) - 32;
      4: begin
        case ($urandom_range(0, 4))
          0: return 32767;
          1: return -32768;
          2: return 256;
          3: return -256;
          default: return -1;
        endcase
      end
      default: return 0;
    endcase
  endfunction

  function automatic cau_pkg::cau_in_t rand_beat();
    cau_pkg::cau_in_t x;
    x = make_beat(2'($urandom_range(0, 3)), rand_word(), rand_word(), rand_word(),
                  rand_word());
    // divisors of zero come up now and then on their own, force a few more
    if (x.func == cau_pkg::OP_DIV && $urandom_range(0, 15) == 0) begin
      x.b_real = '0;
      x.b_imag = '0;
    end
    return x;
  endfunction

  // receiver: random stall bursts, plus a long hold-off on request
  always @(posedge clk) begin
    int  stall_left;
    logic rdy;
    rdy = 1'b1;
    if (hold_request > 0) begin
      hold_request <= hold_request - 1;
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (receiver_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      rdy = 1'b0;
    end
    out_ready <= rdy;
  end

  // result checker: a beat seen at the falling edge is taken at the next rising edge
  always @(negedge clk) begin
    cau_pkg::cau_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        result_count++;
        if (want.status == cau_pkg::ST_SAT) sat_count++;
        if (want.status == cau_pkg::ST_DZ) dz_count++;
        if (out_data.res_real !== want.res_real) begin
          $display("%0t: res_real expected %0d got %0d", $time, want.res_real,
                   out_data.res_real);
          error_count++;
        end
        if (out_data.res_imag !== want.res_imag) begin
          $display("%0t: res_imag expected %0d got %0d", $time, want.res_imag,
                   out_data.res_imag);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status,
                   out_data.status);
          error_count++;
        end
      end
    end
  end

  // corner operands on every operation
  task automatic test_corners();
    cau_pkg::op_t op;
    for (int f = 0; f < 4; f++) begin
      op = cau_pkg::op_t'(f);
      send_beat(make_beat(op, 32767, 32767, 32767, 32767));
      send_beat(make_beat(op, -32768, -32768, -32768, -32768));
      send_beat(make_beat(op, 32767, -32768, -32768, 32767));
      send_beat(make_beat(op, -1, 1, 1, -1));
    end
    // truncation toward zero on negative fractions
    send_beat(make_beat(cau_pkg::OP_MUL, -1, 0, 1, 0));
    send_beat(make_beat(cau_pkg::OP_MUL, -300, 7, 129, -3));
    send_beat(make_beat(cau_pkg::OP_DIV, 1, -1, 768, 0));
    send_beat(make_beat(cau_pkg::OP_DIV, 2560, -512, 256, 256));
    // zero divisor, with a zero and a nonzero dividend
    send_beat(make_beat(cau_pkg::OP_DIV, 1234, -4321, 0, 0));
    send_beat(make_beat(cau_pkg::OP_DIV, 0, 0, 0, 0));
    // tiny divisor blows up into saturation
    send_beat(make_beat(cau_pkg::OP_DIV, 32767, -32768, 1, 0));
  endtask

  // random operands with idling on both sides
  task automatic test_random(input int count);
    sender_idle_en = 1'b1;
    receiver_idle_en = 1'b1;
    repeat (count) send_beat(rand_beat());
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_backpressure();
    sender_idle_en = 1'b0;
    receiver_idle_en = 1'b0;
    hold_request <= 200;
    repeat (60) send_beat(rand_beat());
  endtask

  // full rate on both sides to close the run
  task automatic test_streaming(input int count);
    sender_idle_en = 1'b0;
    receiver_idle_en = 1'b0;
    repeat (count) send_beat(rand_beat());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_random(700);
    test_backpressure();
    test_random(300);
    test_streaming(270);
    finish_sending();
    // drain, then idle before the report
    for (int i = 0; i < 20000 && pending_results.size() != 0; i++) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    repeat (40) @(posedge clk);
    $display("covered %0d results: add %0d, sub %0d, mul %0d, div %0d", result_count,
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("saturated %0d, divide by zero %0d, one long receiver hold-off", sat_count,
             dz_count);
    if (error_count == 0) begin
      $display("complex_arithmetic_unit verification clean");
    end else begin
      $display("complex_arithmetic_unit verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3200000;
    $display("complex_arithmetic_unit verification failed");
    $finish;
  end

endmodule
`default_nettype wire
